[design/stbs_pkg.sv]
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types and constants for the sorted-table binary search core.
// ----------------------------------------------------------------------------
`default_nettype none

package stbs_pkg;

    // Default table depth; the core takes it as a parameter.
    localparam int TABLE_DEPTH_DEF = 1024;

    // Fixed field widths of the transaction payloads.
    localparam int COUNT_W = 11;
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;

    // Operation codes.
    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef struct packed {
        logic                      operation;
        logic [INDEX_W-1:0]        entry_index;
        logic signed [VALUE_W-1:0] item_value;
    } t_in_item;

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] position;
    } t_out_item;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_DONE
    } t_state;

endpackage : stbs_pkg

`default_nettype wire

[design/stbs_ram.sv]
// ----------------------------------------------------------------------------
// stbs_ram
// Single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule : stbs_ram

`default_nettype wire

[design/sorted_table_binary_search_core.sv]
// A write transaction is written to the table when accepted. A search issues
// its first read when accepted, then makes one bisection step per cycle (at
// most log2(depth)+1 steps, so 11 for a 1024-entry table; none when empty)
// and loads the result register once it is free or being taken. Throughput:
// one transaction at a time, as input is held off during a search. Reset is
// synchronous, active low, clears control state and the entry count; the table holds no reset.
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core
// Holds a sorted table of signed 32-bit entries in a RAM and bisects it for a
// search key, returning a found flag and the matching position.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_table_binary_search_core #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // entry_count register
    input  wire logic                          i_cfg_we,
    input  wire logic [stbs_pkg::COUNT_W-1:0]  i_cfg_wdata,
    // input transactions
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire stbs_pkg::t_in_item            i_in_data,
    // result transactions
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output stbs_pkg::t_out_item                o_out_data
);

    // Address width of the table, and a width that also holds the depth
    // itself (bounds of the search interval run from 0 to the depth).
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = AW + 1;
    // Width wide enough for both the count register and the depth.
    localparam int XW = (NW > stbs_pkg::COUNT_W) ? NW : stbs_pkg::COUNT_W;
    // Width wide enough for both the write index and the depth.
    localparam int IW = (NW > stbs_pkg::INDEX_W) ? NW : stbs_pkg::INDEX_W;

    // Registers
    stbs_pkg::t_state                 r_state, n_state;
    logic [stbs_pkg::COUNT_W-1:0]     r_count;
    logic signed [stbs_pkg::VALUE_W-1:0] r_key, n_key;
    logic [NW-1:0]                    r_lo, n_lo;   // first candidate
    logic [NW-1:0]                    r_hi, n_hi;   // one past the last candidate
    logic [NW-1:0]                    r_mid, n_mid; // entry being read
    logic                             r_found, n_found;
    logic [stbs_pkg::INDEX_W-1:0]     r_pos, n_pos;
    logic                             r_out_valid, n_out_valid;
    stbs_pkg::t_out_item              r_out, n_out;

    // RAM ports
    logic                             mem_we;
    logic [AW-1:0]                    mem_waddr;
    logic                             mem_re;
    logic [AW-1:0]                    mem_raddr;
    logic [stbs_pkg::VALUE_W-1:0]     mem_rdata;

    // Helpers
    logic                             in_acc;
    logic [XW-1:0]                    count_x;
    logic [NW-1:0]                    count_sat;
    logic                             idx_in_range;
    logic signed [stbs_pkg::VALUE_W-1:0] entry;
    logic [NW-1:0]                    step_lo;
    logic [NW-1:0]                    step_hi;

    // Midpoint of the half-open interval [lo, hi): lo + floor((hi-1-lo)/2).
    function automatic logic [NW-1:0] mid_of(input logic [NW-1:0] lo,
                                             input logic [NW-1:0] hi);
        logic [NW-1:0] span;
        span = hi - lo - NW'(1);
        return lo + (span >> 1);
    endfunction

    // ------------------------------------------------------------------
    // Table storage
    // ------------------------------------------------------------------
    stbs_ram #(
        .WIDTH (stbs_pkg::VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_in_data.item_value),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // Input is taken only while no search is under way.
    assign o_in_ready = (r_state == stbs_pkg::S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;

    // Saturate the programmed count to the table depth.
    assign count_x   = XW'(r_count);
    assign count_sat = (count_x > XW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : NW'(count_x);

    // Drop writes beyond the table.
    assign idx_in_range = IW'(i_in_data.entry_index) < IW'(TABLE_DEPTH);
    assign mem_we       = in_acc && (i_in_data.operation == stbs_pkg::OP_WRITE)
                          && idx_in_range;
    assign mem_waddr    = AW'(i_in_data.entry_index);

    // Entry read in the previous cycle, at r_mid.
    assign entry = $signed(mem_rdata);

    // Narrowed interval after a miss at r_mid: go left when the entry is
    // greater than the key, right otherwise.
    assign step_lo = (entry > r_key) ? r_lo : (r_mid + NW'(1));
    assign step_hi = (entry > r_key) ? r_mid : r_hi;

    // ------------------------------------------------------------------
    // Search sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_key       = r_key;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_found     = r_found;
        n_pos       = r_pos;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        mem_re      = 1'b0;
        mem_raddr   = AW'(r_mid);

        // Release the result register once the consumer takes it.
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            stbs_pkg::S_IDLE: begin
                if (in_acc && (i_in_data.operation == stbs_pkg::OP_SEARCH)) begin
                    n_key = i_in_data.item_value;
                    if (count_sat == '0) begin
                        // Empty table: answer not found straight away.
                        n_found = 1'b0;
                        n_pos   = '0;
                        n_state = stbs_pkg::S_DONE;
                    end else begin
                        // Issue the first read at the middle of the counted entries.
                        n_lo      = '0;
                        n_hi      = count_sat;
                        n_mid     = mid_of('0, count_sat);
                        mem_re    = 1'b1;
                        mem_raddr = AW'(n_mid);
                        n_state   = stbs_pkg::S_CMP;
                    end
                end
            end
            stbs_pkg::S_CMP: begin
                if (entry == r_key) begin
                    n_found = 1'b1;
                    n_pos   = stbs_pkg::INDEX_W'(r_mid);
                    n_state = stbs_pkg::S_DONE;
                end else if (step_lo < step_hi) begin
                    // Narrow and read the next midpoint in the same cycle.
                    n_lo      = step_lo;
                    n_hi      = step_hi;
                    n_mid     = mid_of(step_lo, step_hi);
                    mem_re    = 1'b1;
                    mem_raddr = AW'(n_mid);
                end else begin
                    n_found = 1'b0;
                    n_pos   = '0;
                    n_state = stbs_pkg::S_DONE;
                end
            end
            stbs_pkg::S_DONE: begin
                // Hold the answer until the result register is free.
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid    = 1'b1;
                    n_out.found    = r_found;
                    n_out.position = r_pos;
                    n_state        = stbs_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = stbs_pkg::S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stbs_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_found <= n_found;
        r_pos   <= n_pos;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // While comparing, the entry under test lies inside a non-empty interval.
    a_mid_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == stbs_pkg::S_CMP |-> (r_lo <= r_mid) && (r_mid < r_hi))
        else $error("midpoint outside search interval");

    // The interval never reaches past the table.
    a_hi_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == stbs_pkg::S_CMP |-> r_hi <= NW'(TABLE_DEPTH))
        else $error("search interval exceeds table depth");

    // A comparison step either continues or finishes; it never drops to idle.
    a_cmp_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == stbs_pkg::S_CMP |=>
            (r_state == stbs_pkg::S_CMP) || (r_state == stbs_pkg::S_DONE))
        else $error("search left without a result");

    // A result is loaded only when the register was free or being taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stbs_pkg::S_DONE) && r_out_valid && !i_out_ready
            |=> $stable(o_out_data) && o_out_valid)
        else $error("pending result overwritten");

endmodule : sorted_table_binary_search_core

`default_nettype wire

[sim/sorted_table_binary_search_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search_core_tb
// Self-checking bench for the sorted-table search core. Directed and random
// table writes and searches are predicted by a behavioural bisection model
// and every result transaction is compared field by field, under several
// idling and back-pressure regimes.
// ----------------------------------------------------------------------------

module sorted_table_binary_search_core_tb;

    localparam int DEPTH           = stbs_pkg::TABLE_DEPTH_DEF;
    // Written part of the table; at full count the first midpoint is its last entry.
    localparam int LOW_SPAN        = DEPTH / 2;
    localparam int DRAIN_CYCLES    = 24;       // longest search plus margin
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int CYCLE_LIMIT     = 1000000;

    localparam logic signed [stbs_pkg::VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [stbs_pkg::VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam longint VAL_MIN_L = -64'sd2147483648;
    localparam longint VAL_MAX_L = 64'sd2147483647;

    logic                          clk         = 1'b0;
    logic                          rst_n       = 1'b0;
    logic                          cfg_we      = 1'b0;
    logic [stbs_pkg::COUNT_W-1:0]  cfg_wdata   = '0;
    logic                          in_valid    = 1'b0;
    logic                          in_ready;
    stbs_pkg::t_in_item            in_data     = '0;
    logic                          out_valid;
    logic                          out_ready   = 1'b0;
    stbs_pkg::t_out_item           out_data;

    // Idling controls, changed by the tests between phases.
    int unsigned         src_idle_pct   = 0;
    int unsigned         sink_stall_pct = 0;
    logic                hold_start     = 1'b0;
    int unsigned         hold_count     = 0;

    // Behavioural copy of the table and the entry_count register.
    logic signed [stbs_pkg::VALUE_W-1:0] shadow_table [DEPTH];
    logic [stbs_pkg::COUNT_W-1:0]        shadow_count = '0;
    stbs_pkg::t_out_item                 pending_matches [$];
    stbs_pkg::t_out_item                 next_match;

    int unsigned         error_count = 0;
    int unsigned         cycle_count = 0;

    sorted_table_binary_search_core #(
        .TABLE_DEPTH (DEPTH)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    always #5 clk = ~clk;

    // Bisect the shadow table for a key, exactly as the core should.
    function automatic stbs_pkg::t_out_item bisect_table(
        input logic signed [stbs_pkg::VALUE_W-1:0] key);
        int                  lo;
        int                  hi;
        int                  mid;
        logic                hit;
        stbs_pkg::t_out_item res;
        lo  = 0;
        hi  = ((shadow_count > DEPTH) ? DEPTH : int'(shadow_count)) - 1;
        hit = 1'b0;
        res = '0;
        while (!hit && lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (shadow_table[mid] == key) begin
                hit          = 1'b1;
                res.found    = 1'b1;
                res.position = mid[stbs_pkg::INDEX_W-1:0];
            end else if (shadow_table[mid] > key) begin
                hi = mid - 1;
            end else begin
                lo = mid + 1;
            end
        end
        return res;
    endfunction

    function automatic int searched_span();
        return (shadow_count > DEPTH) ? DEPTH : int'(shadow_count);
    endfunction

    // Mostly keys that are present, then their neighbours, then anything.
    function automatic logic signed [stbs_pkg::VALUE_W-1:0] pick_key();
        int          span;
        int unsigned r;
        span = searched_span();
        r    = $urandom_range(0, 99);
        if (span > 0 && r < 65)
            return shadow_table[$urandom_range(0, span - 1)];
        if (span > 0 && r < 80)
            return shadow_table[$urandom_range(0, span - 1)] + ($urandom_range(0, 1) ? 1 : -1);
        if (r < 92)
            return $signed($urandom);
        return $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
    endfunction

    // Keys no greater than the last written entry, so a full-count search
    // turns left at the first midpoint and stays inside the written half.
    function automatic logic signed [stbs_pkg::VALUE_W-1:0] pick_low_key();
        logic signed [stbs_pkg::VALUE_W-1:0] key;
        int unsigned                         r;
        r = $urandom_range(0, 99);
        if (r < 70)
            key = shadow_table[$urandom_range(0, LOW_SPAN - 1)];
        else if (r < 90)
            key = shadow_table[$urandom_range(0, LOW_SPAN - 1)] - 1;
        else
            key = VAL_MIN;
        if (key > shadow_table[LOW_SPAN-1])
            key = VAL_MIN;
        return key;
    endfunction

    // Offer one transaction and hold it until accepted; update the model then.
    task automatic send_item(input logic op, input logic [stbs_pkg::INDEX_W-1:0] idx,
                             input logic signed [stbs_pkg::VALUE_W-1:0] val);
        stbs_pkg::t_in_item item;
        item.operation   = op;
        item.entry_index = idx;
        item.item_value  = val;
        if ($urandom_range(0, 99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < src_idle_pct) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (op == stbs_pkg::OP_WRITE)
            shadow_table[idx] = val;
        else
            pending_matches.push_back(bisect_table(val));
    endtask

    task automatic search_for(input logic signed [stbs_pkg::VALUE_W-1:0] key);
        send_item(stbs_pkg::OP_SEARCH, stbs_pkg::INDEX_W'($urandom_range(0, DEPTH - 1)), key);
    endtask

    // Wait for every result, then let a trailing write settle.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_matches.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_entry_count(input logic [stbs_pkg::COUNT_W-1:0] n);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= n;
        @(posedge clk);
        cfg_we       <= 1'b0;
        shadow_count  = n;
    endtask

    task automatic set_idling(input int unsigned src_pct, input int unsigned sink_pct);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
    endtask

    // Write entries 0..n-1 in ascending order, duplicates allowed.
    task automatic fill_sorted(input int n);
        longint level;
        longint stride;
        int     i;
        stride = longint'(1) << $urandom_range(0, 22);
        level  = longint'($signed($urandom)) - (longint'(n) * stride) / 2;
        if ($urandom_range(0, 9) == 0)
            level = VAL_MIN_L;
        for (i = 0; i < n; i++) begin
            if (level < VAL_MIN_L)
                level = VAL_MIN_L;
            if (level > VAL_MAX_L || (i == n - 1 && $urandom_range(0, 9) == 0))
                level = VAL_MAX_L;
            send_item(stbs_pkg::OP_WRITE, i[stbs_pkg::INDEX_W-1:0], level[stbs_pkg::VALUE_W-1:0]);
            level += $urandom_range(0, int'(stride));
        end
    endtask

    task automatic test_empty_table();
        // Count is zero out of reset: nothing is read, every search misses.
        search_for(32'sd0);
        search_for(VAL_MIN);
        search_for(VAL_MAX);
    endtask

    task automatic test_boundary_values();
        send_item(stbs_pkg::OP_WRITE, 10'd0, VAL_MIN);
        send_item(stbs_pkg::OP_WRITE, 10'd1, -32'sd1);
        send_item(stbs_pkg::OP_WRITE, 10'd2, 32'sd0);
        send_item(stbs_pkg::OP_WRITE, 10'd3, 32'sd1);
        send_item(stbs_pkg::OP_WRITE, 10'd4, VAL_MAX - 1);
        send_item(stbs_pkg::OP_WRITE, 10'd5, VAL_MAX);
        set_entry_count(11'd6);
        search_for(VAL_MIN);
        search_for(-32'sd1);
        search_for(32'sd0);
        search_for(VAL_MAX);
        search_for(32'sd2);
        search_for(VAL_MIN + 1);
        set_entry_count(11'd1);
        search_for(VAL_MIN);
        search_for(32'sd0);
        // Break the ordering: bisection may now miss a present entry.
        set_entry_count(11'd6);
        send_item(stbs_pkg::OP_WRITE, 10'd0, VAL_MAX);
        search_for(-32'sd1);
        search_for(VAL_MAX);
    endtask

    task automatic test_full_table();
        int i;
        // Fill the lower half; full-count searches below never leave it.
        fill_sorted(LOW_SPAN);
        set_entry_count(DEPTH[stbs_pkg::COUNT_W-1:0]);
        search_for(shadow_table[0]);
        search_for(shadow_table[LOW_SPAN-1]);
        for (i = 0; i < 20; i++) search_for(pick_low_key());
        // Count above the depth saturates to the depth.
        set_entry_count({stbs_pkg::COUNT_W{1'b1}});
        for (i = 0; i < 10; i++) search_for(pick_low_key());
    endtask

    task automatic test_backpressure();
        int i;
        set_idling(0, 0);
        set_entry_count(11'd48);
        // Hold the result side off and keep offering searches meanwhile.
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        for (i = 0; i < 24; i++) search_for(pick_key());
    endtask

    task automatic test_random_traffic(input int unsigned src_pct, input int unsigned sink_pct);
        int          phase;
        int          i;
        int unsigned r;
        int          n;
        set_idling(src_pct, sink_pct);
        for (phase = 0; phase < 2; phase++) begin
            r = $urandom_range(0, 99);
            if (r < 5)       n = 0;
            else if (r < 15) n = LOW_SPAN;
            else if (r < 35) n = $urandom_range(65, LOW_SPAN - 1);
            else             n = $urandom_range(1, 64);
            set_entry_count(n[stbs_pkg::COUNT_W-1:0]);
            for (i = 0; i < 25; i++) begin
                // Drop in the odd stray write that may break the ordering.
                if ($urandom_range(0, 99) < 8)
                    send_item(stbs_pkg::OP_WRITE,
                              stbs_pkg::INDEX_W'($urandom_range(0, DEPTH - 1)),
                              $signed($urandom));
                else
                    search_for(pick_key());
            end
        end
    endtask

    // Result side: ready with random stalls, or a counted hold-off.
    always @(posedge clk) begin
        if (hold_start) begin
            hold_count <= HOLD_OFF_CYCLES;
            out_ready  <= 1'b0;
        end else if (hold_count != 0) begin
            hold_count <= hold_count - 1;
            out_ready  <= 1'b0;
        end else begin
            out_ready  <= ($urandom_range(0, 99) >= sink_stall_pct);
        end
    end

    // Compare each accepted result with the oldest prediction.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            if (pending_matches.size() == 0) begin
                $display("%0t: unexpected result found=%0b position=%0d",
                         $time, out_data.found, out_data.position);
                error_count++;
            end else begin
                next_match = pending_matches.pop_front();
                if (out_data.found !== next_match.found) begin
                    $display("%0t: found mismatch expected %0b actual %0b",
                             $time, next_match.found, out_data.found);
                    error_count++;
                end
                if (out_data.position !== next_match.position) begin
                    $display("%0t: position mismatch expected %0d actual %0d",
                             $time, next_match.position, out_data.position);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: cycle limit reached, %0d results outstanding",
                     $time, pending_matches.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_table();
        test_boundary_values();
        test_full_table();
        test_backpressure();
        test_random_traffic(0, 0);
        test_random_traffic(88, 0);
        test_random_traffic(0, 88);
        test_random_traffic(25, 25);

        drain_results();
        if (error_count == 0 && pending_matches.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

[files.f]
design/stbs_pkg.sv
design/stbs_ram.sv
design/sorted_table_binary_search_core.sv
sim/sorted_table_binary_search_core_tb.sv
